// ===== hw/rtl/mpsm_pkg.sv =====
package mpsm_pkg;

   localparam logic [2:0] CMD_PATTERN = 3'd0;
   localparam logic [2:0] CMD_BUILD   = 3'd1;
   localparam logic [2:0] CMD_TEXT    = 3'd2;
   localparam logic [2:0] CMD_CLEAR   = 3'd3;
   localparam logic [2:0] CMD_RESTART = 3'd4;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_LETTER   = 3'd1;
   localparam logic [2:0] ERR_NODES    = 3'd2;
   localparam logic [2:0] ERR_PATTERNS = 3'd3;
   localparam logic [2:0] ERR_NOTBUILT = 3'd4;

   localparam logic KIND_HIT = 1'b0;
   localparam logic KIND_ERR = 1'b1;

   localparam logic [7:0] LETTER_LOW  = 8'd65;
   localparam logic [7:0] LETTER_HIGH = 8'd90;

   // hits reported per text beat at most
   localparam int RESULT_LIMIT = 16;
   localparam int K_BITS       = $clog2(RESULT_LIMIT + 1);

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] symbol;
      logic       pattern_end;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [3:0]  pattern_number;
      logic [15:0] start_position;
      logic [2:0]  error_code;
      logic        last_result;
   } rsp_type;

   // output stage operations, at most one per cycle
   typedef struct packed {
      logic push;    // stage a hit, send the one staged before
      logic flush;   // send the staged hit as the last of its beat
      logic single;  // send the item at once as the only result
   } ostage_ctl_type;

endpackage

// ===== hw/rtl/mpsm_if.sv =====
interface mpsm_req_if;
   logic             valid;
   logic             ready;
   mpsm_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mpsm_rsp_if;
   logic             valid;
   logic             ready;
   mpsm_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/mpsm_out_stage.sv =====
module mpsm_out_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  mpsm_pkg::ostage_ctl_type ctl,
   input  mpsm_pkg::rsp_type        item,
   output logic                     ready,
   mpsm_rsp_if.source               rsp
);
   import mpsm_pkg::*;

   rsp_type out_ff, out_in, hold_ff, hold_in;
   logic    out_v_ff, out_v_in, hold_v_ff, hold_v_in;
   logic    free;

   assign free  = !out_v_ff || rsp.ready;
   assign ready = free;

   always_comb begin
      out_in    = out_ff;
      hold_in   = hold_ff;
      out_v_in  = out_v_ff && !rsp.ready;
      hold_v_in = hold_v_ff;
      if (free) begin
         if (ctl.single) begin
            out_in             = item;
            out_in.last_result = 1'b1;
            out_v_in           = 1'b1;
         end else if (ctl.push) begin
            if (hold_v_ff) begin
               out_in             = hold_ff;
               out_in.last_result = 1'b0;
               out_v_in           = 1'b1;
            end
            hold_in   = item;
            hold_v_in = 1'b1;
         end else if (ctl.flush && hold_v_ff) begin
            out_in             = hold_ff;
            out_in.last_result = 1'b1;
            out_v_in           = 1'b1;
            hold_v_in          = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         hold_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         hold_v_ff <= hold_v_in;
      end
      out_ff  <= out_in;
      hold_ff <= hold_in;
   end

   assign rsp.valid   = out_v_ff;
   assign rsp.payload = out_ff;

   a_single_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.single |-> !hold_v_ff) else $error("single result with a hit staged");
   a_ops_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.push, ctl.flush, ctl.single})) else $error("output ops overlap");
   a_last_clean: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_ff.last_result |-> !hold_v_ff)
      else $error("hit staged behind a last beat");

endmodule

// ===== hw/rtl/multi_pattern_string_matcher.sv =====
// Aho-Corasick matcher over A..Z. Load patterns one letter per beat (command 0, pattern_end on
// the last letter), send command 1 to build failure and output links, then stream text with
// command 2; each text beat yields zero or more hits (pattern number, start position) and the
// last of them carries last_result. Errors come back as a single result with kind set. Each
// step is a registered read of one of the trie memories, run by one sequencer, one beat at a
// time. A text letter follows failure links until a goto edge or the root, then walks the
// output chain and sends the hits of each node on it, up to RESULT_LIMIT per beat; loading a
// letter may append behind the patterns already ending at the same node; the build visits
// each root letter, then each queued node letter by letter, walking failure links for each
// child. After reset and after a clear command the goto memory is swept to zero, all
// MAX_NODES * ALPHABET_SIZE slots (6656 by default), with no beat taken meanwhile. A result
// still waiting at the output stops the sequencer at its next hand-over, even when no hit is
// staged behind it.
module multi_pattern_string_matcher #(
   parameter int MAX_NODES     = 256,
   parameter int MAX_PATTERNS  = 16,
   parameter int ALPHABET_SIZE = 26,
   parameter int POSITION_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   mpsm_req_if.sink   req_stream,
   mpsm_rsp_if.source rsp_stream
);
   import mpsm_pkg::*;

   localparam int NB  = $clog2(MAX_NODES);
   localparam int NCB = $clog2(MAX_NODES + 1);
   localparam int LB  = $clog2(ALPHABET_SIZE);
   localparam int PB  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
   localparam int PCB = $clog2(MAX_PATTERNS + 1);
   localparam int GD  = MAX_NODES * ALPHABET_SIZE;
   localparam int GB  = $clog2(GD);

   localparam logic [4:0] S_CLR    = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_ERR    = 5'd2;
   localparam logic [4:0] S_LD     = 5'd3;
   localparam logic [4:0] S_AT_FP  = 5'd4;
   localparam logic [4:0] S_AT_SN  = 5'd5;
   localparam logic [4:0] S_B_RC   = 5'd6;
   localparam logic [4:0] S_B_RCQ  = 5'd7;
   localparam logic [4:0] S_B_HEAD = 5'd8;
   localparam logic [4:0] S_B_U    = 5'd9;
   localparam logic [4:0] S_B_UF   = 5'd10;
   localparam logic [4:0] S_B_C    = 5'd11;
   localparam logic [4:0] S_B_CQ   = 5'd12;
   localparam logic [4:0] S_B_W    = 5'd13;
   localparam logic [4:0] S_B_WQ   = 5'd14;
   localparam logic [4:0] S_B_WF   = 5'd15;
   localparam logic [4:0] S_B_OL   = 5'd16;
   localparam logic [4:0] S_T_W    = 5'd17;
   localparam logic [4:0] S_T_WQ   = 5'd18;
   localparam logic [4:0] S_T_WF   = 5'd19;
   localparam logic [4:0] S_T_N    = 5'd20;
   localparam logic [4:0] S_T_E    = 5'd21;
   localparam logic [4:0] S_T_SN   = 5'd22;
   localparam logic [4:0] S_T_CH   = 5'd23;
   localparam logic [4:0] S_T_END  = 5'd24;

   // goto slot of (node, letter)
   function automatic logic [GB-1:0] ga(input logic [NB-1:0] n, input logic [LB-1:0] c);
      return GB'(GB'(n) * GB'(ALPHABET_SIZE) + GB'(c));
   endfunction

   // ---------------- memories ----------------
   logic [NB-1:0] gt_ram [GD];            // goto: child node, 0 = none
   logic [NB-1:0] fl_ram [MAX_NODES];     // failure link
   logic [NB-1:0] ol_ram [MAX_NODES];     // output link, 0 = none
   logic [NB-1:0] dp_ram [MAX_NODES];     // node depth
   logic [PB-1:0] fp_ram [MAX_NODES];     // first pattern at node
   logic [PB-1:0] sn_ram [MAX_PATTERNS];  // next pattern at same node
   logic [NB-1:0] bq_ram [MAX_NODES];     // breadth-first queue

   logic [GB-1:0] gt_ra, gt_wa;
   logic [NB-1:0] gt_wd, gt_rd_ff;
   logic          gt_we;
   logic [NB-1:0] fl_ra, fl_wa, fl_wd, fl_rd_ff;
   logic          fl_we;
   logic [NB-1:0] ol_ra, ol_wa, ol_wd, ol_rd_ff;
   logic          ol_we;
   logic [NB-1:0] dp_ra, dp_wa, dp_wd, dp_rd_ff;
   logic          dp_we;
   logic [NB-1:0] fp_ra, fp_wa;
   logic [PB-1:0] fp_wd, fp_rd_ff;
   logic          fp_we;
   logic [PB-1:0] sn_ra, sn_wa, sn_wd, sn_rd_ff;
   logic          sn_we;
   logic [NB-1:0] bq_ra, bq_wa, bq_wd, bq_rd_ff;
   logic          bq_we;

   always_ff @(posedge clock) begin
      if (gt_we) gt_ram[gt_wa] <= gt_wd;
      gt_rd_ff <= gt_ram[gt_ra];
   end
   always_ff @(posedge clock) begin
      if (fl_we) fl_ram[fl_wa] <= fl_wd;
      fl_rd_ff <= fl_ram[fl_ra];
   end
   always_ff @(posedge clock) begin
      if (ol_we) ol_ram[ol_wa] <= ol_wd;
      ol_rd_ff <= ol_ram[ol_ra];
   end
   always_ff @(posedge clock) begin
      if (dp_we) dp_ram[dp_wa] <= dp_wd;
      dp_rd_ff <= dp_ram[dp_ra];
   end
   always_ff @(posedge clock) begin
      if (fp_we) fp_ram[fp_wa] <= fp_wd;
      fp_rd_ff <= fp_ram[fp_ra];
   end
   always_ff @(posedge clock) begin
      if (sn_we) sn_ram[sn_wa] <= sn_wd;
      sn_rd_ff <= sn_ram[sn_ra];
   end
   always_ff @(posedge clock) begin
      if (bq_we) bq_ram[bq_wa] <= bq_wd;
      bq_rd_ff <= bq_ram[bq_ra];
   end

   // ---------------- sequencer state ----------------
   logic [4:0]               state_ff, state_in;
   logic [GB-1:0]            clr_ff, clr_in;
   logic [LB-1:0]            letter_ff, letter_in;    // current letter / build letter
   logic                     pend_ff, pend_in;
   logic [NCB-1:0]           node_cnt_ff, node_cnt_in;
   logic [PCB-1:0]           pat_cnt_ff, pat_cnt_in;
   logic [NB-1:0]            load_ff, load_in;
   logic [NB-1:0]            load_dep_ff, load_dep_in;
   logic [NB-1:0]            match_ff, match_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic                     built_ff, built_in;
   logic [MAX_NODES-1:0]     has_ff, has_in;          // node holds a pattern
   logic [MAX_PATTERNS-1:0]  hn_ff, hn_in;            // pattern has a same-node successor
   logic [NCB-1:0]           head_ff, head_in, tail_ff, tail_in;
   logic [NB-1:0]            u_ff, u_in, uf_ff, uf_in, f_ff, f_in, v_ff, v_in, g_ff, g_in;
   logic [NB-1:0]            tnext_ff, tnext_in;
   logic [PB-1:0]            p_ff, p_in;
   logic [K_BITS-1:0]        k_ff, k_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [2:0]               err_ff, err_in;

   ostage_ctl_type ctl;
   rsp_type        item;
   logic           os_ready;

   // symbol decode
   logic [7:0]    sym_off;
   logic          sym_ok;
   logic [NB-1:0] new_node, nx;
   logic          created;
   logic [NB-1:0] g_sel;
   logic [PB-1:0] at_q;
   logic [PB-1:0] pat_id;

   assign sym_off  = req_stream.payload.symbol - LETTER_LOW;
   assign sym_ok   = (req_stream.payload.symbol >= LETTER_LOW)
                  && (req_stream.payload.symbol <= LETTER_HIGH)
                  && (32'(sym_off) < ALPHABET_SIZE);
   assign new_node = node_cnt_ff[NB-1:0];
   assign pat_id   = pat_cnt_ff[PB-1:0];
   assign g_sel    = (gt_rd_ff == v_ff) ? '0 : gt_rd_ff;
   assign at_q     = (state_ff == S_AT_FP) ? fp_rd_ff : sn_rd_ff;

   assign req_stream.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      letter_in   = letter_ff;
      pend_in     = pend_ff;
      node_cnt_in = node_cnt_ff;
      pat_cnt_in  = pat_cnt_ff;
      load_in     = load_ff;
      load_dep_in = load_dep_ff;
      match_in    = match_ff;
      pos_in      = pos_ff;
      built_in    = built_ff;
      has_in      = has_ff;
      hn_in       = hn_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      u_in        = u_ff;
      uf_in       = uf_ff;
      f_in        = f_ff;
      v_in        = v_ff;
      g_in        = g_ff;
      tnext_in    = tnext_ff;
      p_in        = p_ff;
      k_in        = k_ff;
      start_in    = start_ff;
      err_in      = err_ff;

      gt_ra = '0; gt_we = 1'b0; gt_wa = '0; gt_wd = '0;
      fl_ra = '0; fl_we = 1'b0; fl_wa = '0; fl_wd = '0;
      ol_ra = '0; ol_we = 1'b0; ol_wa = '0; ol_wd = '0;
      dp_ra = '0; dp_we = 1'b0; dp_wa = '0; dp_wd = '0;
      fp_ra = '0; fp_we = 1'b0; fp_wa = '0; fp_wd = '0;
      sn_ra = '0; sn_we = 1'b0; sn_wa = '0; sn_wd = '0;
      bq_ra = '0; bq_we = 1'b0; bq_wa = '0; bq_wd = '0;

      ctl     = '0;
      nx      = gt_rd_ff;
      created = 1'b0;

      case (state_ff)
         S_CLR: begin
            gt_we  = 1'b1;
            gt_wa  = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == GB'(GD - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_stream.valid) begin
               letter_in = sym_off[LB-1:0];
               case (req_stream.payload.command)
                  CMD_PATTERN: begin
                     built_in = 1'b0;
                     if (!sym_ok) begin
                        load_in = '0; load_dep_in = '0;
                        err_in = ERR_LETTER; state_in = S_ERR;
                     end else if (pat_cnt_ff >= PCB'(MAX_PATTERNS)) begin
                        load_in = '0; load_dep_in = '0;
                        err_in = ERR_PATTERNS; state_in = S_ERR;
                     end else begin
                        gt_ra    = ga(load_ff, sym_off[LB-1:0]);
                        pend_in  = req_stream.payload.pattern_end;
                        state_in = S_LD;
                     end
                  end
                  CMD_BUILD: begin
                     fl_we = 1'b1; fl_wa = '0; fl_wd = '0;
                     ol_we = 1'b1; ol_wa = '0; ol_wd = '0;
                     letter_in = '0;
                     head_in   = '0;
                     tail_in   = '0;
                     state_in  = S_B_RC;
                  end
                  CMD_TEXT: begin
                     if (!built_ff) begin
                        err_in = ERR_NOTBUILT; state_in = S_ERR;
                     end else if (!sym_ok) begin
                        match_in = '0;
                        pos_in   = pos_ff + 1'b1;
                        err_in   = ERR_LETTER; state_in = S_ERR;
                     end else begin
                        f_in     = match_ff;
                        k_in     = '0;
                        state_in = S_T_W;
                     end
                  end
                  CMD_CLEAR: begin
                     node_cnt_in = NCB'(1);
                     pat_cnt_in  = '0;
                     load_in     = '0;
                     load_dep_in = '0;
                     match_in    = '0;
                     pos_in      = '0;
                     built_in    = 1'b0;
                     has_in      = '0;
                     hn_in       = '0;
                     head_in     = '0;
                     tail_in     = '0;
                     clr_in      = '0;
                     state_in    = S_CLR;
                  end
                  CMD_RESTART: begin
                     match_in = '0;
                     pos_in   = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_ERR: begin
            ctl.single = 1'b1;
            if (os_ready) state_in = S_IDLE;
         end
         S_LD: begin
            if (gt_rd_ff == '0) begin
               if (node_cnt_ff >= NCB'(MAX_NODES)) begin
                  load_in = '0; load_dep_in = '0;
                  err_in = ERR_NODES; state_in = S_ERR;
               end else begin
                  nx      = new_node;
                  created = 1'b1;
                  gt_we = 1'b1; gt_wa = ga(load_ff, letter_ff); gt_wd = new_node;
                  dp_we = 1'b1; dp_wa = new_node; dp_wd = load_dep_ff + 1'b1;
                  node_cnt_in      = node_cnt_ff + 1'b1;
                  has_in[new_node] = 1'b0;
               end
            end
            if (gt_rd_ff != '0 || node_cnt_ff < NCB'(MAX_NODES)) begin
               load_in     = nx;
               load_dep_in = load_dep_ff + 1'b1;
               state_in    = S_IDLE;
               if (pend_ff) begin
                  hn_in[pat_id] = 1'b0;
                  load_in       = '0;
                  load_dep_in   = '0;
                  if (created || !has_ff[nx]) begin
                     has_in[nx] = 1'b1;
                     fp_we = 1'b1; fp_wa = nx; fp_wd = pat_id;
                     pat_cnt_in = pat_cnt_ff + 1'b1;
                  end else begin
                     // append behind the patterns already ending here
                     fp_ra    = nx;
                     state_in = S_AT_FP;
                  end
               end
            end
         end
         S_AT_FP, S_AT_SN: begin
            if (hn_ff[at_q]) begin
               sn_ra    = at_q;
               state_in = S_AT_SN;
            end else begin
               sn_we = 1'b1; sn_wa = at_q; sn_wd = pat_id;
               hn_in[at_q] = 1'b1;
               pat_cnt_in  = pat_cnt_ff + 1'b1;
               state_in    = S_IDLE;
            end
         end
         // root children: failure and output links point to the root
         S_B_RC: begin
            gt_ra    = ga('0, letter_ff);
            state_in = S_B_RCQ;
         end
         S_B_RCQ: begin
            if (gt_rd_ff != '0 && tail_ff < NCB'(MAX_NODES)) begin
               fl_we = 1'b1; fl_wa = gt_rd_ff; fl_wd = '0;
               ol_we = 1'b1; ol_wa = gt_rd_ff; ol_wd = '0;
               bq_we = 1'b1; bq_wa = tail_ff[NB-1:0]; bq_wd = gt_rd_ff;
               tail_in = tail_ff + 1'b1;
            end
            if (letter_ff == LB'(ALPHABET_SIZE - 1)) begin
               state_in = S_B_HEAD;
            end else begin
               letter_in = letter_ff + 1'b1;
               state_in  = S_B_RC;
            end
         end
         S_B_HEAD: begin
            if (head_ff == tail_ff) begin
               load_in     = '0;
               load_dep_in = '0;
               match_in    = '0;
               pos_in      = '0;
               built_in    = 1'b1;
               state_in    = S_IDLE;
            end else begin
               bq_ra    = head_ff[NB-1:0];
               head_in  = head_ff + 1'b1;
               state_in = S_B_U;
            end
         end
         S_B_U: begin
            u_in     = bq_rd_ff;
            fl_ra    = bq_rd_ff;
            state_in = S_B_UF;
         end
         S_B_UF: begin
            uf_in     = fl_rd_ff;
            letter_in = '0;
            state_in  = S_B_C;
         end
         S_B_C: begin
            gt_ra    = ga(u_ff, letter_ff);
            state_in = S_B_CQ;
         end
         S_B_CQ: begin
            v_in = gt_rd_ff;
            f_in = uf_ff;
            if (gt_rd_ff != '0 && tail_ff < NCB'(MAX_NODES)) begin
               state_in = S_B_W;
            end else if (letter_ff == LB'(ALPHABET_SIZE - 1)) begin
               state_in = S_B_HEAD;
            end else begin
               letter_in = letter_ff + 1'b1;
               state_in  = S_B_C;
            end
         end
         S_B_W: begin
            gt_ra    = ga(f_ff, letter_ff);
            state_in = S_B_WQ;
         end
         S_B_WQ: begin
            if (f_ff != '0 && gt_rd_ff == '0) begin
               fl_ra    = f_ff;
               state_in = S_B_WF;
            end else begin
               g_in     = g_sel;
               ol_ra    = g_sel;
               state_in = S_B_OL;
            end
         end
         S_B_WF: begin
            f_in     = fl_rd_ff;
            state_in = S_B_W;
         end
         S_B_OL: begin
            fl_we = 1'b1; fl_wa = v_ff; fl_wd = g_ff;
            ol_we = 1'b1; ol_wa = v_ff; ol_wd = has_ff[g_ff] ? g_ff : ol_rd_ff;
            bq_we = 1'b1; bq_wa = tail_ff[NB-1:0]; bq_wd = v_ff;
            tail_in = tail_ff + 1'b1;
            if (letter_ff == LB'(ALPHABET_SIZE - 1)) begin
               state_in = S_B_HEAD;
            end else begin
               letter_in = letter_ff + 1'b1;
               state_in  = S_B_C;
            end
         end
         // text: follow failure links until a goto edge or the root
         S_T_W: begin
            gt_ra    = ga(f_ff, letter_ff);
            state_in = S_T_WQ;
         end
         S_T_WQ: begin
            if (f_ff != '0 && gt_rd_ff == '0) begin
               fl_ra    = f_ff;
               state_in = S_T_WF;
            end else begin
               match_in = gt_rd_ff;
               f_in     = gt_rd_ff;
               dp_ra    = gt_rd_ff;
               fp_ra    = gt_rd_ff;
               ol_ra    = gt_rd_ff;
               state_in = S_T_N;
            end
         end
         S_T_WF: begin
            f_in     = fl_rd_ff;
            state_in = S_T_W;
         end
         S_T_N: begin
            tnext_in = ol_rd_ff;
            if (has_ff[f_ff] && k_ff < K_BITS'(RESULT_LIMIT)) begin
               start_in = pos_ff + 1'b1 - POSITION_BITS'(dp_rd_ff);
               p_in     = fp_rd_ff;
               state_in = S_T_E;
            end else begin
               state_in = S_T_CH;
            end
         end
         S_T_E: begin
            ctl.push = 1'b1;
            if (os_ready) begin
               k_in = k_ff + 1'b1;
               if (hn_ff[p_ff] && k_ff < K_BITS'(RESULT_LIMIT - 1)) begin
                  sn_ra    = p_ff;
                  state_in = S_T_SN;
               end else begin
                  state_in = S_T_CH;
               end
            end
         end
         S_T_SN: begin
            p_in     = sn_rd_ff;
            state_in = S_T_E;
         end
         S_T_CH: begin
            if (tnext_ff != '0 && k_ff < K_BITS'(RESULT_LIMIT)) begin
               f_in     = tnext_ff;
               dp_ra    = tnext_ff;
               fp_ra    = tnext_ff;
               ol_ra    = tnext_ff;
               state_in = S_T_N;
            end else begin
               state_in = S_T_END;
            end
         end
         S_T_END: begin
            if (k_ff == '0) begin
               pos_in   = pos_ff + 1'b1;
               state_in = S_IDLE;
            end else begin
               ctl.flush = 1'b1;
               if (os_ready) begin
                  pos_in   = pos_ff + 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      item = '0;
      if (state_ff == S_ERR) begin
         item.kind       = KIND_ERR;
         item.error_code = err_ff;
      end else begin
         item.kind           = KIND_HIT;
         item.pattern_number = 4'(p_ff);
         item.start_position = 16'(start_ff);
         item.error_code     = ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLR;
         clr_ff      <= '0;
         node_cnt_ff <= NCB'(1);
         pat_cnt_ff  <= '0;
         load_ff     <= '0;
         load_dep_ff <= '0;
         match_ff    <= '0;
         pos_ff      <= '0;
         built_ff    <= 1'b0;
         has_ff      <= '0;
         hn_ff       <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         k_ff        <= '0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         node_cnt_ff <= node_cnt_in;
         pat_cnt_ff  <= pat_cnt_in;
         load_ff     <= load_in;
         load_dep_ff <= load_dep_in;
         match_ff    <= match_in;
         pos_ff      <= pos_in;
         built_ff    <= built_in;
         has_ff      <= has_in;
         hn_ff       <= hn_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         k_ff        <= k_in;
      end
      letter_ff <= letter_in;
      pend_ff   <= pend_in;
      u_ff      <= u_in;
      uf_ff     <= uf_in;
      f_ff      <= f_in;
      v_ff      <= v_in;
      g_ff      <= g_in;
      tnext_ff  <= tnext_in;
      p_ff      <= p_in;
      start_ff  <= start_in;
      err_ff    <= err_in;
   end

   mpsm_out_stage u_out (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .item  (item),
      .ready (os_ready),
      .rsp   (rsp_stream)
   );

   a_built_root: assert property (@(posedge clock) disable iff (reset)
      built_ff |-> load_ff == '0) else $error("built trie with a pattern half loaded");
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      tail_ff < node_cnt_ff || state_ff == S_CLR || state_ff == S_IDLE)
      else $error("bfs queue outgrew the node table");
   a_hit_limit: assert property (@(posedge clock) disable iff (reset)
      k_ff <= K_BITS'(RESULT_LIMIT)) else $error("hit count over limit");
   a_clear_sweep: assert property (@(posedge clock) disable iff (reset)
      req_stream.valid && req_stream.ready && req_stream.payload.command == CMD_CLEAR
      |=> state_ff == S_CLR && clr_ff == '0) else $error("clear did not start the sweep");

endmodule
